// ----- sv/jcsc_pkg.sv -----
// Package for the JSON container syntax checker: types, codes, character constants and classes.
`timescale 1ns / 1ps
`default_nettype none

package jcsc_pkg;

  localparam int DEPTH_BITS_DEFAULT = 8;

  // Parse phase, one-hot
  typedef enum logic [9:0] {
    PH_FIRST      = 10'b00_0000_0001,
    PH_KEY_WAIT   = 10'b00_0000_0010,
    PH_KEY_STR    = 10'b00_0000_0100,
    PH_COLON      = 10'b00_0000_1000,
    PH_VALUE_WAIT = 10'b00_0001_0000,
    PH_NEST_SQ    = 10'b00_0010_0000,
    PH_NEST_CB    = 10'b00_0100_0000,
    PH_STRING     = 10'b00_1000_0000,
    PH_TOKEN      = 10'b01_0000_0000,
    PH_AFTER      = 10'b10_0000_0000
  } phase_t;

  typedef logic [2:0] status_t;

  localparam status_t ST_PENDING      = 3'd0;
  localparam status_t ST_VALID        = 3'd1;
  localparam status_t ST_KEY_NOT_STR  = 3'd2;
  localparam status_t ST_NO_COLON     = 3'd3;
  localparam status_t ST_NO_VALUE     = 3'd4;
  localparam status_t ST_NO_SEP       = 3'd5;
  localparam status_t ST_UNTERMINATED = 3'd6;

  // Register byte addresses
  localparam logic [2:0] ADDR_CONTAINER_MODE = 3'd0;

  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_CB_OPEN   = 8'h7B;
  localparam logic [7:0] CH_CB_CLOSE  = 8'h7D;
  localparam logic [7:0] CH_SQ_OPEN   = 8'h5B;
  localparam logic [7:0] CH_SQ_CLOSE  = 8'h5D;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_DOT       = 8'h2E;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_token_char(input logic [7:0] c);
    return is_digit(c) || is_alpha(c) || (c == CH_DOT) || (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

endpackage

`default_nettype wire

// ----- sv/json_container_syntax_checker.sv -----
// JSON container body syntax checker: one body byte per word, one status word back.
//
//  Channel   Dir  Handshake                   Content
//  s_axis    in   s_axis_tvalid/tready        tdata[7:0] text_byte, tuser restart,
//                                             tlast end_of_text
//  m_axis    out  m_axis_tvalid/tready        tdata[2:0] check_status, tuser status_final
//  apb       in   psel/penable/pwrite/pready  byte 0: container_mode (bit 0)
//
// Every accepted word gives exactly one status word, in the cycle after it is
// accepted. The parse state is updated by a single level of next-state logic at
// the accept edge, and the status is held in one output register, so a word can
// be accepted every cycle. s_axis_tready drops only while the output register is
// full and m_axis_tready is low. Reset (rst, synchronous) clears the parse state,
// empties the output register and sets container_mode to object.
`timescale 1ns / 1ps
`default_nettype none

module json_container_syntax_checker
  import jcsc_pkg::*;
#(
  parameter int DEPTH_BITS = DEPTH_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // stream in
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  wire logic        s_axis_tuser,   // restart
  input  wire logic        s_axis_tlast,   // end_of_text
  // stream out
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [2:0] check_status, [7:3] zero
  output logic             m_axis_tuser,   // status_final
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Registers
  logic                  container_mode;
  phase_t                parse_phase;
  logic [DEPTH_BITS-1:0] nest_depth;
  logic                  escape_pending;
  status_t               verdict_latched;
  status_t               check_status;

  phase_t                parse_phase_next;
  logic [DEPTH_BITS-1:0] nest_depth_next;
  logic                  escape_pending_next;
  status_t               verdict_latched_next;

  logic       in_accept;
  logic [7:0] c;
  logic [7:0] closer;

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  // Accept while the output register is empty or being emptied this cycle
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign c             = s_axis_tdata;
  assign closer        = container_mode ? CH_CB_CLOSE : CH_SQ_CLOSE;

  // ---------------------------------------------------------------------------
  // Configuration port: always ready, single register
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_CONTAINER_MODE) ? {31'd0, container_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      container_mode <= 1'b1;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_CONTAINER_MODE)) begin
      container_mode <= pwdata[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Next-state logic for one body byte
  // ---------------------------------------------------------------------------
  always_comb begin
    // A restart byte starts from a clean state, then is checked as usual
    if (s_axis_tuser) begin
      parse_phase_next     = PH_FIRST;
      nest_depth_next      = '0;
      escape_pending_next  = 1'b0;
      verdict_latched_next = ST_PENDING;
    end else begin
      parse_phase_next     = parse_phase;
      nest_depth_next      = nest_depth;
      escape_pending_next  = escape_pending;
      verdict_latched_next = verdict_latched;
    end

    // Once a verdict is latched, hold everything until the next restart
    if (verdict_latched_next == ST_PENDING) begin
      unique case (parse_phase_next) inside
        PH_KEY_WAIT: begin
          if (!is_ws(c)) begin
            if (c == CH_QUOTE) begin
              parse_phase_next    = PH_KEY_STR;
              escape_pending_next = 1'b0;
            end else begin
              verdict_latched_next = ST_KEY_NOT_STR;
            end
          end
        end
        PH_KEY_STR, PH_STRING: begin
          if (escape_pending_next) begin
            escape_pending_next = 1'b0;
          end else if (c == CH_BACKSLASH) begin
            escape_pending_next = 1'b1;
          end else if (c == CH_QUOTE) begin
            parse_phase_next = (parse_phase_next == PH_KEY_STR) ? PH_COLON : PH_AFTER;
          end
        end
        PH_COLON: begin
          if (!is_ws(c)) begin
            if (c == CH_COLON) begin
              parse_phase_next = PH_VALUE_WAIT;
            end else begin
              verdict_latched_next = ST_NO_COLON;
            end
          end
        end
        PH_NEST_SQ, PH_NEST_CB: begin
          // Count only brackets of the kind that opened this nested value
          if (c == ((parse_phase_next == PH_NEST_SQ) ? CH_SQ_OPEN : CH_CB_OPEN)) begin
            if (nest_depth_next != '1) begin
              nest_depth_next = nest_depth_next + 1'b1;
            end
          end else if (c == ((parse_phase_next == PH_NEST_SQ) ? CH_SQ_CLOSE : CH_CB_CLOSE)) begin
            if (nest_depth_next <= DEPTH_BITS'(1)) begin
              nest_depth_next  = '0;
              parse_phase_next = PH_AFTER;
            end else begin
              nest_depth_next = nest_depth_next - 1'b1;
            end
          end
        end
        PH_VALUE_WAIT, PH_TOKEN, PH_AFTER, PH_FIRST: begin
          if ((parse_phase_next == PH_TOKEN) && is_token_char(c)) begin
            // stay inside the number or bare word
          end else if (is_ws(c)) begin
            if (parse_phase_next == PH_TOKEN) begin
              parse_phase_next = PH_AFTER;
            end
          end else if ((parse_phase_next == PH_TOKEN) || (parse_phase_next == PH_AFTER)) begin
            // Byte after a value: separator, closer or error
            parse_phase_next = PH_AFTER;
            if (c == CH_COMMA) begin
              parse_phase_next = container_mode ? PH_KEY_WAIT : PH_VALUE_WAIT;
            end else if (c == closer) begin
              verdict_latched_next = ST_VALID;
            end else begin
              verdict_latched_next = ST_NO_SEP;
            end
          end else if ((parse_phase_next == PH_FIRST) && (c == closer)) begin
            // Empty body
            verdict_latched_next = ST_VALID;
          end else if ((parse_phase_next == PH_FIRST) && container_mode) begin
            if (c == CH_QUOTE) begin
              parse_phase_next    = PH_KEY_STR;
              escape_pending_next = 1'b0;
            end else begin
              verdict_latched_next = ST_KEY_NOT_STR;
            end
          end else begin
            // Start of a value
            if (c == CH_QUOTE) begin
              parse_phase_next    = PH_STRING;
              escape_pending_next = 1'b0;
            end else if (c == CH_SQ_OPEN) begin
              parse_phase_next = PH_NEST_SQ;
              nest_depth_next  = DEPTH_BITS'(1);
            end else if (c == CH_CB_OPEN) begin
              parse_phase_next = PH_NEST_CB;
              nest_depth_next  = DEPTH_BITS'(1);
            end else if (is_digit(c) || (c == CH_MINUS) || is_alpha(c)) begin
              parse_phase_next = PH_TOKEN;
            end else begin
              verdict_latched_next = ST_NO_VALUE;
            end
          end
        end
        default: begin
          parse_phase_next = PH_FIRST;
        end
      endcase

      if (s_axis_tlast && (verdict_latched_next == ST_PENDING)) begin
        verdict_latched_next = ST_UNTERMINATED;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Parse state: advance on every accepted word
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase     <= PH_FIRST;
      nest_depth      <= '0;
      escape_pending  <= 1'b0;
      verdict_latched <= ST_PENDING;
    end else if (in_accept) begin
      parse_phase     <= parse_phase_next;
      nest_depth      <= nest_depth_next;
      escape_pending  <= escape_pending_next;
      verdict_latched <= verdict_latched_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: load on accept, drop once taken
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      check_status <= verdict_latched_next;
    end
  end

  assign m_axis_tdata = {5'd0, check_status};
  assign m_axis_tuser = (check_status != ST_PENDING);

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_verdict_held : assert property (@(posedge clk) disable iff (rst)
    ((verdict_latched != ST_PENDING) && !(in_accept && s_axis_tuser))
      |=> (verdict_latched == $past(verdict_latched)))
    else $error("latched verdict changed without restart");

  a_end_gives_verdict : assert property (@(posedge clk) disable iff (rst)
    (in_accept && s_axis_tlast) |=> (verdict_latched != ST_PENDING))
    else $error("end of text left verdict pending");

  a_depth_in_nest : assert property (@(posedge clk) disable iff (rst)
    (nest_depth != '0) |-> ((parse_phase == PH_NEST_SQ) || (parse_phase == PH_NEST_CB)))
    else $error("nesting depth nonzero outside nested value");

  a_status_matches_state : assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (m_axis_tvalid && (check_status == verdict_latched)))
    else $error("output status differs from latched verdict");

endmodule

`default_nettype wire
